### src/qpfm_pkg.sv
// Shared types, constants and helpers for the QPSK packet framer/modulator.
// No dependencies.
package qpfm_pkg;

  localparam int AMP_W   = 15;
  localparam int LEVEL_W = 16;
  localparam int CRC_W   = 16;

  localparam logic [AMP_W-1:0] AMP_RESET = 15'd22938;
  localparam logic [CRC_W-1:0] CRC_INIT  = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY  = 16'h1021;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // byte positions within one job
  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] POS_PRE_FIRST = 4'd0;
  localparam logic [POS_W-1:0] POS_PRE_LAST  = 4'd5;
  localparam logic [POS_W-1:0] POS_DATA      = 4'd6;
  localparam logic [POS_W-1:0] POS_CRC_HI    = 4'd7;
  localparam logic [POS_W-1:0] POS_CRC_LO    = 4'd8;

  typedef struct packed {
    logic [7:0]       data;
    logic             start;
    logic             last;
    logic [CRC_W-1:0] crc;
  } job_t;

  function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0] byte_in);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {byte_in, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] preamble_byte(input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd4:    b = 8'hE7;
      3'd5:    b = 8'h18;
      default: b = 8'hDC;
    endcase
    return b;
  endfunction

endpackage

### src/qpsk_packet_framer_modulator.sv
// Top level of the QPSK packet framer/modulator: amplitude register and the
// front end, job queue and symbol sequencer. Depends on qpfm_pkg and submodules.
//
// Each accepted byte yields four QPSK symbols, one per cycle from the output
// register while out_stall is low. The first byte of a packet adds 24
// preamble/sync symbols and the last byte adds 8 CRC symbols. The symbol
// sequencer issues one symbol per cycle unless out_stall holds it; a four-entry
// job queue lets input bytes be taken while symbols are still going out.
module qpsk_packet_framer_modulator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [qpfm_pkg::AMP_W-1:0] cfg_amplitude,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_last_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [15:0]         out_i_level,
  output logic signed [15:0]         out_q_level,
  output logic                       out_run_end,
  output logic                       out_packet_end
);
  import qpfm_pkg::*;

  logic [AMP_W-1:0] amp_r;
  logic             push, pop, full, empty;
  job_t             wr_job, rd_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) amp_r <= AMP_RESET;
    else if (cfg_valid && cfg_ready) amp_r <= cfg_amplitude;
  end

  qpfm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .fifo_full    (full),
    .push         (push),
    .job          (wr_job)
  );

  qpfm_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .full   (full),
    .empty  (empty)
  );

  qpfm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .amplitude      (amp_r),
    .fifo_empty     (empty),
    .fifo_job       (rd_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_i_level    (out_i_level),
    .out_q_level    (out_q_level),
    .out_run_end    (out_run_end),
    .out_packet_end (out_packet_end)
  );

endmodule

### src/qpfm_front.sv
// Front end: accepts packet bytes, tracks packet start and runs the CRC.
// Depends on qpfm_pkg.
module qpfm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_data_byte,
  input  logic          in_last_byte,
  input  logic          fifo_full,
  output logic          push,
  output qpfm_pkg::job_t job
);
  import qpfm_pkg::*;

  logic             in_packet_r, in_packet_nxt;
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [CRC_W-1:0] crc_base;
  logic [CRC_W-1:0] crc_new;

  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full;

  assign crc_base = in_packet_r ? crc_r : CRC_INIT;
  assign crc_new  = crc_update(crc_base, in_data_byte);

  always_comb begin
    job.data  = in_data_byte;
    job.start = !in_packet_r;
    job.last  = in_last_byte;
    job.crc   = crc_new;
  end

  always_comb begin
    in_packet_nxt = in_packet_r;
    crc_nxt       = crc_r;
    if (push) begin
      in_packet_nxt = !in_last_byte;
      crc_nxt       = in_last_byte ? CRC_INIT : crc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r <= 1'b0;
      crc_r       <= CRC_INIT;
    end else begin
      in_packet_r <= in_packet_nxt;
      crc_r       <= crc_nxt;
    end
  end

endmodule

### src/qpfm_fifo.sv
// Short job queue between front end and symbol sequencer.
// Depends on qpfm_pkg.
module qpfm_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  qpfm_pkg::job_t wr_job,
  input  logic           pop,
  output qpfm_pkg::job_t rd_job,
  output logic           full,
  output logic           empty
);
  import qpfm_pkg::*;

  job_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_job;
  end

endmodule

### src/qpfm_back.sv
// Back end: walks preamble (first byte of a packet), data and CRC (last byte)
// bytes of each job, one QPSK symbol a cycle unless stalled, into the output register. Depends on qpfm_pkg.
module qpfm_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [qpfm_pkg::AMP_W-1:0] amplitude,
  input  logic                      fifo_empty,
  input  qpfm_pkg::job_t            fifo_job,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [15:0]        out_i_level,
  output logic signed [15:0]        out_q_level,
  output logic                      out_run_end,
  output logic                      out_packet_end
);
  import qpfm_pkg::*;

  logic             busy_r;
  job_t             job_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]       sym_r;
  logic             out_valid_r;
  logic [LEVEL_W-1:0] i_r, q_r;
  logic             run_end_r, packet_end_r;

  logic             emit, done;
  logic [7:0]       cur_byte, shifted;
  logic [LEVEL_W-1:0] lvl_pos, lvl_neg;

  assign emit = busy_r && (!out_valid_r || !out_stall);
  assign pop  = !fifo_empty && (!busy_r || (emit && done));

  always_comb begin
    pos_nxt = pos_r + 1'b1;
    done    = 1'b0;
    unique case (pos_r)
      POS_DATA: begin
        cur_byte = job_r.data;
        done     = (sym_r == 2'd3) && !job_r.last;
      end
      POS_CRC_HI: cur_byte = job_r.crc[15:8];
      POS_CRC_LO: begin
        cur_byte = job_r.crc[7:0];
        done     = (sym_r == 2'd3);
      end
      default: cur_byte = preamble_byte(pos_r[2:0]);
    endcase
  end

  assign shifted = cur_byte << {sym_r, 1'b0};
  assign lvl_pos = {1'b0, amplitude};
  assign lvl_neg = ~lvl_pos + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= POS_PRE_FIRST;
      sym_r       <= 2'd0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (pop) begin
        busy_r <= 1'b1;
        pos_r  <= fifo_job.start ? POS_PRE_FIRST : POS_DATA;
        sym_r  <= 2'd0;
      end else if (emit) begin
        if (done) begin
          busy_r <= 1'b0;
        end else begin
          sym_r <= sym_r + 1'b1;
          if (sym_r == 2'd3) pos_r <= pos_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= fifo_job;
    if (emit) begin
      i_r          <= shifted[7] ? lvl_neg : lvl_pos;
      q_r          <= shifted[6] ? lvl_neg : lvl_pos;
      run_end_r    <= done;
      packet_end_r <= done && (pos_r == POS_CRC_LO);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_i_level    = i_r;
  assign out_q_level    = q_r;
  assign out_run_end    = run_end_r;
  assign out_packet_end = packet_end_r;

endmodule

### sim/tb_qpsk_packet_framer_modulator.sv
`timescale 1ns / 100ps
// Testbench for qpsk_packet_framer_modulator: a scoreboard class predicts the
// symbols of every byte, with preamble/CRC at packet start/end, and checks each output word.
// Depends on qpfm_pkg and the block's RTL.

typedef struct packed {
  logic [15:0] i_level;
  logic [15:0] q_level;
  logic        run_end;
  logic        packet_end;
} symbol_t;

class symbol_scoreboard;
  localparam logic [7:0]  PREAMBLE = 8'hDC;
  localparam logic [7:0]  SYNC_HI  = 8'hE7;
  localparam logic [7:0]  SYNC_LO  = 8'h18;
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_GEN  = 16'h1021;

  logic [qpfm_pkg::AMP_W-1:0] amplitude;
  bit                         in_packet;
  logic [15:0]                crc;
  symbol_t                    symbols_due[$];
  int                         errors;
  int                         words_seen;

  function new();
    amplitude  = qpfm_pkg::AMP_RESET;
    in_packet  = 1'b0;
    crc        = CRC_SEED;
    errors     = 0;
    words_seen = 0;
  endfunction

  function void set_amplitude(logic [qpfm_pkg::AMP_W-1:0] a);
    amplitude = a;
  endfunction

  function int pending();
    return symbols_due.size();
  endfunction

  // bit 0 gives +amplitude, bit 1 its two's complement negation
  function logic [15:0] level_of(bit b);
    logic [15:0] mag;
    mag = {1'b0, amplitude};
    return b ? 16'h0000 - mag : mag;
  endfunction

  function void queue_byte(logic [7:0] b);
    symbol_t s;
    for (int k = 3; k >= 0; k--) begin
      s.i_level    = level_of(b[2*k+1]);
      s.q_level    = level_of(b[2*k]);
      s.run_end    = 1'b0;
      s.packet_end = 1'b0;
      symbols_due  = {symbols_due, s};
    end
  endfunction

  function void note_byte(logic [7:0] d, bit last);
    symbol_t tail;
    int      tail_idx;
    if (!in_packet) begin
      for (int k = 0; k < 4; k++) queue_byte(PREAMBLE);
      queue_byte(SYNC_HI);
      queue_byte(SYNC_LO);
      crc       = CRC_SEED;
      in_packet = 1'b1;
    end
    // bitwise form: feedback is the top CRC bit xor the incoming data bit
    for (int b = 7; b >= 0; b--)
      crc = {crc[14:0], 1'b0} ^ ((crc[15] ^ d[b]) ? CRC_GEN : 16'h0000);
    queue_byte(d);
    if (last) begin
      queue_byte(crc[15:8]);
      queue_byte(crc[7:0]);
      in_packet = 1'b0;
      crc       = CRC_SEED;
    end
    tail_idx              = symbols_due.size() - 1;
    tail                  = symbols_due[tail_idx];
    tail.run_end          = 1'b1;
    tail.packet_end       = last;
    symbols_due[tail_idx] = tail;
  endfunction

  function void flag(string what);
    if (errors < 10) $display("%s", what);
    errors++;
  endfunction

  function void check_symbol(symbol_t got);
    symbol_t want;
    words_seen++;
    if (symbols_due.size() == 0) begin
      flag($sformatf("word %0d unexpected: i=%0d q=%0d run_end=%b packet_end=%b",
                     words_seen, $signed(got.i_level), $signed(got.q_level),
                     got.run_end, got.packet_end));
      return;
    end
    want = symbols_due.pop_front();
    if (got.i_level !== want.i_level || got.q_level !== want.q_level ||
        got.run_end !== want.run_end || got.packet_end !== want.packet_end)
      flag($sformatf({"word %0d: i exp %0d got %0d, q exp %0d got %0d, ",
                      "run_end exp %b got %b, packet_end exp %b got %b"},
                     words_seen, $signed(want.i_level), $signed(got.i_level),
                     $signed(want.q_level), $signed(got.q_level),
                     want.run_end, got.run_end, want.packet_end, got.packet_end));
  endfunction
endclass

module tb_qpsk_packet_framer_modulator;
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       cfg_valid      = 1'b0;
  logic                       cfg_ready;
  logic [qpfm_pkg::AMP_W-1:0] cfg_amplitude  = '0;
  logic                       in_valid       = 1'b0;
  logic                       in_stall;
  logic [7:0]                 in_data_byte   = '0;
  logic                       in_last_byte   = 1'b0;
  logic                       out_valid;
  logic                       out_stall      = 1'b0;
  logic signed [15:0]         out_i_level;
  logic signed [15:0]         out_q_level;
  logic                       out_run_end;
  logic                       out_packet_end;

  bit idling_on    = 1'b1;
  bit hold_request = 1'b0;

  symbol_scoreboard sb = new();

  qpsk_packet_framer_modulator u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_amplitude (cfg_amplitude),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_i_level   (out_i_level),
    .out_q_level   (out_q_level),
    .out_run_end   (out_run_end),
    .out_packet_end(out_packet_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_request = 1'b0;
      end else if (idling_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 9)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 19)) @(posedge clk);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_symbol({out_i_level, out_q_level, out_run_end, out_packet_end});
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_qpsk_packet_framer_modulator: errors");
    $finish;
  end

  task automatic send_byte(input logic [7:0] d, input bit last);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_byte(d, last);
  endtask

  // mostly short packets, now and then a long one
  task automatic send_packets(input int count);
    int left;
    left = 0;
    for (int n = 0; n < count; n++) begin
      if (left == 0)
        left = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      send_byte(8'($urandom_range(0, 255)), left == 1);
      left--;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_amplitude(input logic [qpfm_pkg::AMP_W-1:0] a);
    settle();
    cfg_amplitude <= a;
    cfg_valid     <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_amplitude(a);
  endtask

  initial begin
    logic [qpfm_pkg::AMP_W-1:0] amp;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset amplitude: one-byte packets at both extremes, then a longer one
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b1);

    // zero amplitude flattens every symbol
    write_amplitude('0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    write_amplitude('1);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    write_amplitude(15'd1);
    send_byte(8'h3C, 1'b1);

    for (int p = 0; p < 4; p++) begin
      amp = 15'($urandom_range(0, 32767));
      write_amplitude(amp);
      if (p == 2) hold_request = 1'b1;
      if (p == 3) idling_on = 1'b0;
      send_packets(30);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_qpsk_packet_framer_modulator: clean");
    else
      $display("tb_qpsk_packet_framer_modulator: errors");
    $finish;
  end
endmodule
